@@ rtl/utf_pkg.sv @@
// Package with the shared types, codes and constants of the UART transmit framer.
`timescale 1ns / 1ps
package utf_pkg;

	localparam int DATA_BITS      = 8;
	localparam int CNT_WIDTH      = $clog2(DATA_BITS);
	localparam int CFG_WIDTH      = 16;
	localparam int CFG_IDX_WIDTH  = 2;
	localparam int PERIOD_WIDTH   = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int STOP_WIDTH     = 2;
	localparam int STOP_CFG_WIDTH = 3;
	localparam int MODE_WIDTH     = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_PARITY_MODE = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_STOP_COUNT  = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_BIT_PERIOD  = 2'd2;

	// Parity selector codes; the unused code means no parity.
	localparam logic [MODE_WIDTH-1:0] PAR_NONE = 2'd0;
	localparam logic [MODE_WIDTH-1:0] PAR_ODD  = 2'd1;
	localparam logic [MODE_WIDTH-1:0] PAR_EVEN = 2'd2;

	localparam logic [STOP_CFG_WIDTH-1:0] STOP_RESET      = 3'd1;
	localparam logic [STOP_CFG_WIDTH-1:0] STOP_MAX        = 3'd4;
	localparam logic [CFG_WIDTH-1:0]      BIT_PERIOD_RESET = 16'd248;

	// One classified frame request handed from the front to the back.
	typedef struct packed {
		logic [DATA_BITS-1:0]  data;
		logic                  has_parity;
		logic                  parity_bit;
		logic [STOP_WIDTH-1:0] stop_last;
	} frame_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DATA,
		ST_PARITY,
		ST_STOP
	} utf_state_t;

endpackage

@@ rtl/uart_tx_framer.sv @@
// Top level of the UART transmit framer: configuration registers and block wiring.
`timescale 1ns / 1ps
// Each byte request on the slave stream becomes one serial frame of ten to fourteen
// line levels on the master stream: a start bit, eight data bits LSB first, an
// optional odd or even parity bit and one to four stop bits, the last stop bit
// flagged by tlast. A pacing counter in the serializer, reloaded from bit_period on
// each accepted level, holds the next level back until it has counted down (no hold
// when bit_period is 0 or 1); with a ready sink and bit_period of 1 the levels leave
// one per cycle and frames follow without a gap. Bytes are classified in a front stage
// and wait in a two-entry queue, so new requests are taken while a frame is still
// being sent. Configuration must be written only while the block is idle.
module uart_tx_framer import utf_pkg::*; #(
	parameter int PERIOD_W = PERIOD_WIDTH,
	parameter int Q_DEPTH  = QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]     cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [7:0]               s_tdata,  // [7:0] data_byte
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [7:0]               m_tdata,  // [0] line_level, [7:1] zero
	output logic                     m_tlast
);

	logic [MODE_WIDTH-1:0]     parity_mode_q;
	logic [STOP_CFG_WIDTH-1:0] stop_count_q;
	logic [PERIOD_W-1:0]       bit_period_q;
	logic                      push_valid;
	logic                      push_ready;
	frame_req_t                push_req;
	logic                      q_valid;
	logic                      q_pop;
	frame_req_t                q_req;
	logic                      line_level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_mode_q <= PAR_NONE;
			stop_count_q  <= STOP_RESET;
			bit_period_q  <= PERIOD_W'(BIT_PERIOD_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PARITY_MODE: parity_mode_q <= cfg_data[MODE_WIDTH-1:0];
				CFG_STOP_COUNT:  stop_count_q  <= cfg_data[STOP_CFG_WIDTH-1:0];
				CFG_BIT_PERIOD:  bit_period_q  <= PERIOD_W'(cfg_data);
				default: ;
			endcase
		end
	end

	utf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.parity_mode (parity_mode_q),
		.stop_count  (stop_count_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.push_valid  (push_valid),
		.push_req    (push_req),
		.push_ready  (push_ready)
	);

	utf_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_req   (push_req),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_req   (q_req)
	);

	utf_back #(
		.PERIOD_W (PERIOD_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.bit_period (bit_period_q),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_level    (line_level),
		.m_last     (m_tlast)
	);

	assign m_tdata = {7'd0, line_level};

	// The frame always closes on a mark level.
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tdata[0])
		else $error("frame end flagged on a space level");

	// A level is held for the configured period before the next one leaves.
	a_pacing: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && (bit_period_q > PERIOD_W'(1))) |=> !m_tvalid)
		else $error("line level left before its bit period ended");

	// After the end of a frame the next level is a start bit or nothing.
	a_start_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tdata[0]))
		else $error("frame did not begin with a start bit");

endmodule

@@ rtl/utf_front.sv @@
// Front end: accepts data bytes and classifies them into frame requests.
`timescale 1ns / 1ps
module utf_front import utf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [MODE_WIDTH-1:0]     parity_mode,
	input  logic [STOP_CFG_WIDTH-1:0] stop_count,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [DATA_BITS-1:0]      s_tdata,
	output logic                      push_valid,
	output frame_req_t                push_req,
	input  logic                      push_ready
);

	logic       valid_s1;
	frame_req_t req_s1;
	frame_req_t req_new;
	logic       push;

	always_comb begin
		req_new.data       = s_tdata;
		req_new.has_parity = (parity_mode == PAR_ODD) || (parity_mode == PAR_EVEN);
		req_new.parity_bit = (^s_tdata) ^ (parity_mode == PAR_ODD);
		// Stop count is clamped to one through four bits.
		if (stop_count == '0) begin
			req_new.stop_last = '0;
		end else if (stop_count > STOP_MAX) begin
			req_new.stop_last = STOP_WIDTH'(STOP_MAX - 3'd1);
		end else begin
			req_new.stop_last = STOP_WIDTH'(stop_count - 3'd1);
		end
	end

	assign push       = valid_s1 && push_ready;
	assign s_tready   = !valid_s1 || push;
	assign push_valid = valid_s1;
	assign push_req   = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= req_new;
		end
	end

endmodule

@@ rtl/utf_queue.sv @@
// Short request queue between the front end and the serializer.
`timescale 1ns / 1ps
module utf_queue import utf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  frame_req_t wr_req,
	output logic       rd_valid,
	input  logic       rd_pop,
	output frame_req_t rd_req
);

	localparam int PTR_WIDTH = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);

	frame_req_t             mem_q [DEPTH];
	logic [PTR_WIDTH-1:0]   wr_ptr_q;
	logic [PTR_WIDTH-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_wr;
	logic                   do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_req   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_req;
		end
	end

endmodule

@@ rtl/utf_back.sv @@
// Back end: serializes frame requests into paced line levels.
`timescale 1ns / 1ps
module utf_back import utf_pkg::*; #(
	parameter int PERIOD_W = PERIOD_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [PERIOD_W-1:0] bit_period,
	input  logic                q_valid,
	input  frame_req_t          q_req,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic                m_level,
	output logic                m_last
);

	utf_state_t              state_q;
	utf_state_t              state_nxt;
	logic [DATA_BITS-1:0]    shift_q;
	logic [CNT_WIDTH-1:0]    bit_cnt_q;
	logic [STOP_WIDTH-1:0]   stop_cnt_q;
	logic                    has_par_q;
	logic                    par_bit_q;
	logic [STOP_WIDTH-1:0]   stop_last_q;
	logic                    out_valid_q;
	logic                    out_level_q;
	logic                    out_last_q;
	logic [PERIOD_W-1:0]     pace_q;
	logic                    pace_ok;
	logic                    out_accept;
	logic                    advance;
	logic                    gen_level;
	logic                    gen_last;
	logic                    last_data;
	logic                    last_stop;

	// The next level may leave once the previous one has been held a full period.
	assign pace_ok    = (pace_q[PERIOD_W-1:1] == '0);
	assign m_tvalid   = out_valid_q && pace_ok;
	assign m_level    = out_level_q;
	assign m_last     = out_last_q;
	assign out_accept = m_tvalid && m_tready;
	assign advance    = (state_q != ST_IDLE) && (!out_valid_q || out_accept);
	assign last_data  = (bit_cnt_q == CNT_WIDTH'(DATA_BITS - 1));
	assign last_stop  = (stop_cnt_q == stop_last_q);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				if (advance) begin
					state_nxt = ST_DATA;
				end
			end
			ST_DATA: begin
				if (advance && last_data) begin
					state_nxt = has_par_q ? ST_PARITY : ST_STOP;
				end
			end
			ST_PARITY: begin
				if (advance) begin
					state_nxt = ST_STOP;
				end
			end
			ST_STOP: begin
				if (advance && last_stop) begin
					state_nxt = q_valid ? ST_START : ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		gen_level = 1'b1;
		gen_last  = 1'b0;
		q_pop     = 1'b0;
		unique case (state_q)
			ST_IDLE:   q_pop     = q_valid;
			ST_START:  gen_level = 1'b0;
			ST_DATA:   gen_level = shift_q[0];
			ST_PARITY: gen_level = par_bit_q;
			ST_STOP: begin
				gen_last = last_stop;
				q_pop    = advance && last_stop && q_valid;
			end
			default: gen_level = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			pace_q      <= '0;
		end else begin
			state_q <= state_nxt;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_accept) begin
				out_valid_q <= 1'b0;
			end
			if (out_accept) begin
				pace_q <= bit_period;
			end else if (!pace_ok) begin
				pace_q <= pace_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_level_q <= gen_level;
			out_last_q  <= gen_last;
		end
		if (q_pop) begin
			shift_q     <= q_req.data;
			has_par_q   <= q_req.has_parity;
			par_bit_q   <= q_req.parity_bit;
			stop_last_q <= q_req.stop_last;
			bit_cnt_q   <= '0;
			stop_cnt_q  <= '0;
		end else if (advance && state_q == ST_DATA) begin
			shift_q   <= shift_q >> 1;
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end else if (advance && state_q == ST_STOP) begin
			stop_cnt_q <= stop_cnt_q + 1'b1;
		end
	end

endmodule

@@ tb/uart_tx_framer_tb.sv @@
// Self-checking testbench for the UART transmit framer with randomized stream traffic.
`timescale 1ns / 1ps
module uart_tx_framer_tb;
	import utf_pkg::*;

	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_WIDTH-1:0] CFG_NO_REG = 2'd3;
	localparam logic [MODE_WIDTH-1:0] PAR_UNUSED = 2'd3;

	typedef struct packed {
		logic level;
		logic last;
	} line_bit_t;

	typedef struct packed {
		logic       pause;
		logic [7:0] data;
	} send_req_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_WIDTH-1:0]     cfg_data;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [7:0]               s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [7:0]               m_tdata;
	logic                     m_tlast;

	// Shadow copy of the configuration registers.
	logic [MODE_WIDTH-1:0]     parity_sel = PAR_NONE;
	logic [STOP_CFG_WIDTH-1:0] stop_sel   = STOP_RESET;
	logic [CFG_WIDTH-1:0]      period_sel = BIT_PERIOD_RESET;

	line_bit_t levels_due[$];
	send_req_t send_backlog[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	int        idle_pct = 12;
	int        hold_left = 0;
	logic      hold_request = 1'b0;
	logic      byte_taken = 1'b0;

	uart_tx_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic void apply_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_WIDTH-1:0] val);
		case (idx)
			CFG_PARITY_MODE: parity_sel = val[MODE_WIDTH-1:0];
			CFG_STOP_COUNT:  stop_sel = val[STOP_CFG_WIDTH-1:0];
			CFG_BIT_PERIOD:  period_sel = val;
			default: ;
		endcase
	endfunction

	// Appends the line levels of one frame to the queue of expected levels.
	function automatic void predict_frame(input logic [7:0] b);
		int stops;
		levels_due.push_back('{level: 1'b0, last: 1'b0});
		for (int i = 0; i < DATA_BITS; i++)
			levels_due.push_back('{level: b[i], last: 1'b0});
		if (parity_sel == PAR_ODD)
			levels_due.push_back('{level: ~(^b), last: 1'b0});
		else if (parity_sel == PAR_EVEN)
			levels_due.push_back('{level: ^b, last: 1'b0});
		stops = int'(stop_sel);
		if (stops < 1)
			stops = 1;
		if (stops > int'(STOP_MAX))
			stops = int'(STOP_MAX);
		for (int k = 0; k < stops; k++)
			levels_due.push_back('{level: 1'b1, last: (k == stops - 1)});
	endfunction

	always @(posedge clk) begin
		line_bit_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("uart_tx_framer regression: fail");
			$finish;
		end else begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			byte_taken = s_tvalid && s_tready;
			if (byte_taken)
				predict_frame(s_tdata);
			if (m_tvalid && m_tready) begin
				if (levels_due.size() == 0) begin
					$error("unexpected level: line_level %0d frame_last %0d", m_tdata[0],
						m_tlast);
					fail_count++;
				end else begin
					want = levels_due.pop_front();
					if (m_tdata[0] !== want.level) begin
						$error("line_level: expected %0d, got %0d", want.level, m_tdata[0]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("frame_last: expected %0d, got %0d", want.last, m_tlast);
						fail_count++;
					end
					if (m_tdata[7:1] !== 7'd0) begin
						$error("tdata padding: expected 0, got %0h", m_tdata[7:1]);
						fail_count++;
					end
				end
			end
		end
	end

	// Byte sender: holds a request until it is taken, may idle between requests.
	always @(negedge clk) begin
		send_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || byte_taken) begin
			if (send_backlog.size() != 0 && send_backlog[0].pause) begin
				if (levels_due.size() == 0)
					void'(send_backlog.pop_front());
				s_tvalid <= 1'b0;
			end else if (send_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req = send_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= req.data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Level sink: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	function automatic bit all_drained();
		return send_backlog.size() == 0 && !s_tvalid && levels_due.size() == 0;
	endfunction

	task automatic wait_drained();
		while (!all_drained())
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [MODE_WIDTH-1:0] mode, input int stops, input int period);
		wait_drained();
		set_reg(CFG_PARITY_MODE, CFG_WIDTH'(mode));
		set_reg(CFG_STOP_COUNT, CFG_WIDTH'(stops));
		set_reg(CFG_BIT_PERIOD, CFG_WIDTH'(period));
		end_writes();
	endtask

	task automatic queue_byte(input logic [7:0] b);
		send_backlog.push_back('{pause: 1'b0, data: b});
	endtask

	initial begin
		logic [CFG_WIDTH-1:0] junk;
		logic [7:0] b;
		logic [7:0] corner_bytes [6];
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PARITY_MODE;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		corner_bytes = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h55, 8'haa};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration first: no parity, one stop bit, slow pacing.
		queue_byte(8'h00);
		queue_byte(8'hff);

		configure(PAR_ODD, 2, 1);
		foreach (corner_bytes[i])
			queue_byte(corner_bytes[i]);

		// Zero period behaves as a bit period of one.
		configure(PAR_EVEN, 4, 0);
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(8'h7f);
		queue_byte(8'hfe);

		// Unused parity code means no parity; zero stop count means one stop bit.
		configure(PAR_UNUSED, 0, 2);
		queue_byte(8'h00);
		queue_byte(8'ha5);
		queue_byte(8'hff);

		// Stop count above four clamps; a write to the unused index changes nothing.
		configure(PAR_ODD, 7, 3);
		set_reg(CFG_NO_REG, 16'hffff);
		end_writes();
		queue_byte(8'h3c);
		queue_byte(8'hc3);
		wait_drained();
		set_reg(CFG_NO_REG, 16'h0000);
		end_writes();
		queue_byte(8'h81);

		// Longest bit period, shortest frame.
		configure(PAR_NONE, 1, 65535);
		queue_byte(8'h96);

		for (int ph = 0; ph < 12; ph++) begin
			wait_drained();
			idle_pct = (ph == 0) ? 0 : 12;
			if ($urandom_range(3) != 0 || ph == 0) begin
				junk = CFG_WIDTH'($urandom);
				junk[MODE_WIDTH-1:0] = MODE_WIDTH'($urandom_range(3));
				set_reg(CFG_PARITY_MODE, junk);
			end
			if ($urandom_range(3) != 0 || ph == 0) begin
				junk = CFG_WIDTH'($urandom);
				junk[STOP_CFG_WIDTH-1:0] = STOP_CFG_WIDTH'($urandom_range(7));
				set_reg(CFG_STOP_COUNT, junk);
			end
			case ($urandom_range(3))
				0: junk = 16'd0;
				1: junk = 16'd1;
				2: junk = CFG_WIDTH'($urandom_range(2, 5));
				default: junk = CFG_WIDTH'($urandom_range(6, 16));
			endcase
			// The hold-off phase runs at full speed so the input side backs up.
			if (ph == 3)
				junk = 16'd1;
			set_reg(CFG_BIT_PERIOD, junk);
			if ($urandom_range(4) == 0)
				set_reg(CFG_NO_REG, CFG_WIDTH'($urandom));
			end_writes();

			n = $urandom_range(26, 34);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(9))
					0: b = 8'h00;
					1: b = 8'hff;
					default: b = 8'($urandom);
				endcase
				queue_byte(b);
				if (ph == 6 && k == n / 2)
					send_backlog.push_back('{pause: 1'b1, data: 8'h00});
			end
			if (ph == 3)
				hold_request = 1'b1;
		end

		idle_pct = 12;
		while (!all_drained())
			@(negedge clk);
		repeat (4 * (int'(period_sel) + 1) + 40) @(negedge clk);
		if (fail_count == 0)
			$display("uart_tx_framer regression: pass");
		else
			$display("uart_tx_framer regression: fail");
		$finish;
	end

endmodule
